// ----- design/bba_pkg.sv -----
package bba_pkg;

  localparam int BLK_W     = 12;
  localparam int TOT_W     = 13;
  localparam int ST_W      = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [TOT_W-1:0] TOTAL_RST    = 13'd4096;
  localparam logic [BLK_W-1:0] RESERVED_RST = 12'd0;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD_FIRST,
    S_SCAN,
    S_FREE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd_first;
    logic scan;
    logic free_chk;
    logic set_range;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic free_bad;
    logic scan_end;
    logic slot_free;
  } stat_t;

endpackage

// ----- design/bba_ifs.sv -----
interface bba_in_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [BLK_W-1:0] block_number;

  modport source(output valid, output kind, output block_number, input ready);
  modport sink(input valid, input kind, input block_number, output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] granted_block;
  status_t          status;

  modport source(output valid, output granted_block, output status, input ready);
  modport sink(input valid, input granted_block, input status, output ready);
endinterface

// ----- design/bba_ram.sv -----
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bba_ctl.sv -----
module bba_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output bba_pkg::cmd_t  cmd,
  input  bba_pkg::stat_t stat
);
  import bba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free && stat.free_bad) begin
          cmd.set_range = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_nxt    = stat.is_free ? S_FREE_CHK : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/bba_dp.sv -----
module bba_dp #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bba_pkg::cmd_t             cmd,
  output bba_pkg::stat_t            stat,
  input  bba_pkg::kind_t            in_kind,
  input  logic [bba_pkg::BLK_W-1:0] in_blk,
  input  logic [bba_pkg::TOT_W-1:0] eff_total,
  input  logic [bba_pkg::BLK_W-1:0] reserved,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [bba_pkg::BLK_W-1:0] out_granted,
  output bba_pkg::status_t          out_status
);
  import bba_pkg::*;

  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OW         = $clog2(WORD_BITS);
  localparam int BASEW      = $clog2(4096 + (WORD_COUNT + 1) * WORD_BITS) + 1;

  // clearing pass
  logic [AW-1:0]        clr_r;

  // latched request, split into bitmap word and bit (WORD_BITS is a power of two)
  kind_t                kind_r;
  logic [BLK_W-1:0]     blk_r;
  logic [BLK_W-1:0]     dvd;
  logic [BLK_W-1:0]     quo_r;
  logic [OW-1:0]        part_r;

  // scan
  logic [BASEW-1:0]     rw_r;
  logic [BASEW-1:0]     ew_r;
  logic [BASEW-1:0]     base_r;
  logic [OW-1:0]        off_r;
  logic                 first_r;
  logic                 pend_r;

  // result and output
  logic [BLK_W-1:0]     res_gb_r;
  status_t              res_st_r;
  logic                 out_valid_r;
  logic [BLK_W-1:0]     out_gb_r;
  status_t              out_st_r;

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [OW-1:0]        idx;
  logic                 found;
  logic [BASEW-1:0]     cand;
  logic [BASEW-1:0]     total_x;
  logic                 past_end;
  logic                 scan_end;
  logic                 scan_ok;
  logic                 bit_set;
  logic                 first_ok;
  logic                 next_ok;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;

  assign ones     = '1;
  assign dvd      = (in_kind == KIND_FREE) ? in_blk : reserved;
  assign total_x  = BASEW'(eff_total);
  assign first_ok = (BASEW'(quo_r) < BASEW'(WORD_COUNT));
  assign next_ok  = (rw_r < BASEW'(WORD_COUNT));

  assign mask      = first_r ? (ones << off_r) : ones;
  assign free_bits = ~rd_data & mask;
  assign found     = |free_bits;
  assign cand      = base_r + BASEW'(idx);
  assign past_end  = (base_r >= total_x);
  assign scan_end  = !pend_r || past_end || found;
  assign scan_ok   = pend_r && !past_end && found && (cand < total_x);
  assign bit_set   = rd_data[off_r];

  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = OW'(i);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ew_r[AW-1:0];
    ram_wdata = rd_data;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (cmd.scan) begin
      ram_we    = scan_ok;
      ram_wdata = rd_data | (WORD_BITS'(1) << idx);
    end else if (cmd.free_chk) begin
      ram_we    = bit_set;
      ram_wdata = rd_data & ~(WORD_BITS'(1) << off_r);
    end
  end

  assign ram_re    = (cmd.rd_first && first_ok) || (cmd.scan && next_ok);
  assign ram_raddr = cmd.rd_first ? AW'(quo_r) : rw_r[AW-1:0];

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      blk_r  <= in_blk;
      quo_r  <= dvd >> OW;
      part_r <= dvd[OW-1:0];
    end

    if (cmd.rd_first) begin
      rw_r    <= BASEW'(quo_r) + BASEW'(1);
      ew_r    <= BASEW'(quo_r);
      base_r  <= BASEW'(reserved) - BASEW'(part_r);
      off_r   <= part_r;
      first_r <= 1'b1;
      pend_r  <= first_ok;
    end else if (cmd.scan) begin
      if (next_ok) begin
        rw_r <= rw_r + BASEW'(1);
      end
      ew_r    <= rw_r;
      base_r  <= base_r + BASEW'(WORD_BITS);
      first_r <= 1'b0;
      pend_r  <= next_ok;
    end

    if (cmd.set_range) begin
      res_gb_r <= '0;
      res_st_r <= ST_RANGE;
    end else if (cmd.scan && scan_end) begin
      res_gb_r <= scan_ok ? cand[BLK_W-1:0] : '0;
      res_st_r <= scan_ok ? ST_OK : ST_FULL;
    end else if (cmd.free_chk) begin
      res_gb_r <= '0;
      res_st_r <= bit_set ? ST_OK : ST_DOUBLE_FREE;
    end

    if (cmd.deliver) begin
      out_gb_r <= res_gb_r;
      out_st_r <= res_st_r;
    end
  end

  assign stat.clr_last  = (clr_r == AW'(WORD_COUNT - 1));
  assign stat.is_free   = (kind_r == KIND_FREE);
  assign stat.free_bad  = (blk_r < reserved) || (TOT_W'(blk_r) >= eff_total);
  assign stat.scan_end  = scan_end;
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_granted = out_gb_r;
  assign out_status  = out_st_r;

endmodule

// ----- design/bitmap_block_allocator.sv -----
// First-fit bitmap block allocator.
// in_ch carries one request per transaction: kind (allocate or free) and
// block_number (the block to free). out_ch returns exactly one transaction per
// request: granted_block and status (ok, no free block, already free, out of
// range). total_blocks and reserved_blocks are written over the APB port; the
// user must do so only while no request is in flight (the block does not enforce it).
// One request is handled at a time. A free passes through a range check, one
// word read, one check/write and a result state before the result is offered;
// a free out of range goes from the range check straight to the result state.
// An allocate passes through the check state, the first word read, the scan and
// the result state; the scan runs from the word holding reserved_blocks up to
// the first free bit or the end of the range, and the bitmap RAM is read at one
// word per cycle. in_ch.ready rises in the cycle the result is first offered.
// After reset the bitmap RAM is cleared one word per cycle with in_ch.ready
// low; APB writes are taken throughout. A stalled out_ch holds its result; the
// next request is still accepted and processed, and waits for the output
// register to drain.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::CFG_AW-1:0]  paddr,
  input  logic [bba_pkg::CFG_DW-1:0]  pwdata,
  output logic [bba_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import bba_pkg::*;

  logic [TOT_W-1:0] total_r;
  logic [BLK_W-1:0] reserved_r;
  logic [TOT_W-1:0] eff_total;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RST;
      reserved_r <= RESERVED_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TOTAL:    total_r    <= pwdata[TOT_W-1:0];
        REG_RESERVED: reserved_r <= pwdata[BLK_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL:    prdata = CFG_DW'(total_r);
      REG_RESERVED: prdata = CFG_DW'(reserved_r);
      default:      prdata = '0;
    endcase
  end

  assign eff_total = (32'(total_r) > 32'(MAX_BLOCKS)) ? TOT_W'(MAX_BLOCKS) : total_r;

  bba_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  bba_dp #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_ch.kind),
    .in_blk     (in_ch.block_number),
    .eff_total  (eff_total),
    .reserved   (reserved_r),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_granted(out_ch.granted_block),
    .out_status (out_ch.status)
  );

endmodule

// ----- design/bba_checker.sv -----
module bba_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bba_pkg::BLK_W-1:0]  granted_block,
  input logic [bba_pkg::ST_W-1:0]   status
);
  import bba_pkg::*;

  // request port not ready right after reset, when the bitmap clearing begins
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port ready right after reset");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request port ready right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(granted_block) && $stable(status))
    else $error("result changed while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (granted_block == '0))
    else $error("nonzero block number on failed request");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .granted_block(out_ch.granted_block),
  .status       (out_ch.status)
);
